>>> design/assert_macros.svh
// Assertion macros for the checker file of the dense Prim block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Concurrent assertion on the house clock and reset.
`define ASSERT_CHK(label, prop) `ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

>>> design/dpm_pkg.sv
// Package for the dense Prim block: controller states, command and status structs.
`timescale 1ns / 1ps
package dpm_pkg;

  // Width of the vertex count register and its value after reset.
  localparam int unsigned CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_SEARCH,
    ST_SDRAIN,
    ST_PICK,
    ST_RELAX,
    ST_RDRAIN,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_we;
    logic run_start;
    logic init_we;
    logic v_clr;
    logic v_one;
    logic v_inc;
    logic search_rd;
    logic relax_rd;
    logic pick_set;
    logic round_inc;
    logic out_rd;
    logic out_ld;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic load_last;
    logic v_last;
    logic round_last;
    logic out_free;
  } sts_t;

endpackage

>>> design/dpm_ctrl.sv
// Controller state machine: load, init, search/relax rounds and result readout.
`timescale 1ns / 1ps
module dpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  dpm_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output dpm_pkg::cmd_t cmd_o
);
  import dpm_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_we = 1'b1;
          if (sts_i.load_last) begin
            cmd_o.run_start = 1'b1;
            cmd_o.v_clr     = 1'b1;
            state_d         = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init_we = 1'b1;
        if (sts_i.v_last) begin
          cmd_o.v_clr = 1'b1;
          state_d     = ST_SEARCH;
        end else begin
          cmd_o.v_inc = 1'b1;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_rd = 1'b1;
        if (sts_i.v_last) begin
          state_d = ST_SDRAIN;
        end else begin
          cmd_o.v_inc = 1'b1;
        end
      end
      // last distance compare lands here
      ST_SDRAIN: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        cmd_o.pick_set = 1'b1;
        cmd_o.v_clr    = 1'b1;
        state_d        = ST_RELAX;
      end
      ST_RELAX: begin
        cmd_o.relax_rd = 1'b1;
        if (sts_i.v_last) begin
          state_d = ST_RDRAIN;
        end else begin
          cmd_o.v_inc = 1'b1;
        end
      end
      // last relax write lands here
      ST_RDRAIN: begin
        if (sts_i.round_last) begin
          cmd_o.v_one = 1'b1;
          state_d     = ST_OUT_RD;
        end else begin
          cmd_o.round_inc = 1'b1;
          cmd_o.v_clr     = 1'b1;
          state_d         = ST_SEARCH;
        end
      end
      ST_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (sts_i.v_last) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.v_inc = 1'b1;
            state_d     = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

>>> design/dpm_datapath.sv
// Datapath: weight and distance memories, counters, minimum search, relax and output register.
`timescale 1ns / 1ps
module dpm_datapath #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpm_pkg::cmd_t                       cmd_i,
  output dpm_pkg::sts_t                       sts_o,
  input  logic                                cfg_valid_i,
  input  logic [dpm_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  logic [WEIGHT_BITS-1:0]              weight_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [$clog2(MAX_VERTICES)-1:0]     vertex_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     parent_o,
  output logic                                last_o
);
  import dpm_pkg::*;

  localparam int unsigned VB    = $clog2(MAX_VERTICES);
  localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = VB + WEIGHT_BITS;
  localparam logic [WEIGHT_BITS-1:0] WMASK = {WEIGHT_BITS{1'b1}};
  localparam logic [CFG_BITS-1:0]    MAXV  = CFG_BITS'(MAX_VERTICES);
  localparam logic [CFG_BITS-1:0]    TWO   = CFG_BITS'(2);

  logic [CFG_BITS-1:0]    vcount_q;
  logic [CFG_BITS-1:0]    nc;
  logic [VB-1:0]          n_m1, n_m2;
  logic [VB-1:0]          row_q, col_q;
  logic [VB-1:0]          v_q, round_q;
  logic [MAX_VERTICES-1:0] incl_q;
  logic [WEIGHT_BITS-1:0] best_q;
  logic [VB-1:0]          pick_q;
  logic                   s1_srch_q, s1_relx_q;
  logic [VB-1:0]          s1_v_q;
  logic [WEIGHT_BITS-1:0] wrd_q;
  logic [EW-1:0]          rd_q;
  logic [WEIGHT_BITS-1:0] rd_dist;
  logic [VB-1:0]          rd_parent;
  logic                   srch_hit, relax_hit;
  logic                   dm_we;
  logic [VB-1:0]          dm_waddr;
  logic [EW-1:0]          dm_wdata;
  logic [AW-1:0]          wm_waddr, wm_raddr;
  logic                   out_valid_q;
  logic [VB-1:0]          vertex_q, parent_q;
  logic                   last_q;

  logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
  logic [EW-1:0]          dist_mem   [MAX_VERTICES];

  // Vertex count register; the count in use is clamped to 2..MAX_VERTICES
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_valid_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (vcount_q < TWO) begin
      nc = TWO;
    end else if (vcount_q > MAXV) begin
      nc = MAXV;
    end else begin
      nc = vcount_q;
    end
    n_m1 = VB'(nc - 1'b1);
    n_m2 = VB'(nc - TWO);
  end

  // Row/column load position; a config write restarts the load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_valid_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.load_we) begin
      if (col_q == n_m1) begin
        col_q <= '0;
        row_q <= (row_q == n_m1) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Scan and round counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      round_q <= '0;
    end else begin
      if (cmd_i.v_clr) begin
        v_q <= '0;
      end else if (cmd_i.v_one) begin
        v_q <= VB'(1);
      end else if (cmd_i.v_inc) begin
        v_q <= v_q + 1'b1;
      end
      if (cmd_i.run_start) begin
        round_q <= '0;
      end else if (cmd_i.round_inc) begin
        round_q <= round_q + 1'b1;
      end
    end
  end

  // Included flags: vertex 0 is in the tree from the start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= '0;
    end else if (cmd_i.run_start) begin
      incl_q    <= '0;
      incl_q[0] <= 1'b1;
    end else if (cmd_i.pick_set) begin
      incl_q[pick_q] <= 1'b1;
    end
  end

  // Weight memory: written on load, read by row of the picked vertex
  assign wm_waddr = AW'(AW'(row_q) * AW'(MAX_VERTICES)) + AW'(col_q);
  assign wm_raddr = AW'(AW'(pick_q) * AW'(MAX_VERTICES)) + AW'(v_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      weight_mem[wm_waddr] <= weight_i;
    end
    if (cmd_i.relax_rd) begin
      wrd_q <= weight_mem[wm_raddr];
    end
  end

  // Distance/parent memory, one write and one read port
  assign rd_dist   = rd_q[WEIGHT_BITS-1:0];
  assign rd_parent = rd_q[EW-1:WEIGHT_BITS];

  assign srch_hit  = s1_srch_q && !incl_q[s1_v_q] && (rd_dist < best_q);
  assign relax_hit = s1_relx_q && (wrd_q != '0) && !incl_q[s1_v_q] && (wrd_q < rd_dist);

  always_comb begin
    dm_we    = cmd_i.init_we || relax_hit;
    dm_waddr = cmd_i.init_we ? v_q : s1_v_q;
    dm_wdata = cmd_i.init_we ? {{VB{1'b0}}, WMASK} : {pick_q, wrd_q};
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dist_mem[dm_waddr] <= dm_wdata;
    end
    if (cmd_i.search_rd || cmd_i.relax_rd || cmd_i.out_rd) begin
      rd_q <= dist_mem[v_q];
    end
  end

  // Read-data stage tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_srch_q <= 1'b0;
      s1_relx_q <= 1'b0;
      s1_v_q    <= '0;
    end else begin
      s1_srch_q <= cmd_i.search_rd;
      s1_relx_q <= cmd_i.relax_rd;
      s1_v_q    <= v_q;
    end
  end

  // Running minimum; first scan cycle seeds the fallback pick
  always_ff @(posedge clk_i) begin
    if (cmd_i.search_rd && (v_q == '0)) begin
      best_q <= WMASK;
      pick_q <= round_q;
    end else if (srch_hit) begin
      best_q <= rd_dist;
      pick_q <= s1_v_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      vertex_q <= v_q;
      parent_q <= rd_parent;
      last_q   <= (v_q == n_m1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = vertex_q;
  assign parent_o    = parent_q;
  assign last_o      = last_q;

  // Status to controller
  always_comb begin
    sts_o.load_last  = (row_q == n_m1) && (col_q == n_m1);
    sts_o.v_last     = (v_q == n_m1);
    sts_o.round_last = (round_q == n_m2);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

>>> design/dense_prim_mst_top.sv
// Top level of the dense Prim minimum spanning tree block.
// Load: one weight word per cycle; the n*n-th word starts a run.
// Run: init, then n-1 rounds of search, pick and relax on the distance memory, then
// a read and a load per result word (n-1 words), a load waiting while the output stalls.
// Scans make one distance memory read per cycle; loading reopens after the last result.
// Reset: asynchronous active low; load position cleared, vertex count 64, no result pending.
`timescale 1ns / 1ps
module dense_prim_mst_top #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_BITS  = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dpm_pkg::CFG_BITS-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [WEIGHT_BITS-1:0]          weight_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [$clog2(MAX_VERTICES)-1:0] vertex_o,
  output logic [$clog2(MAX_VERTICES)-1:0] parent_o,
  output logic                            last_o
);
  import dpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  dpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  dpm_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .weight_i    (weight_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .vertex_o    (vertex_o),
    .parent_o    (parent_o),
    .last_o      (last_o)
  );

endmodule

>>> design/dpm_checker.sv
// Port-level checker for the dense Prim block and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dpm_checker #(
  parameter int unsigned VERT_BITS = 6
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [VERT_BITS-1:0] vertex_o,
  input logic [VERT_BITS-1:0] parent_o,
  input logic                 last_o
);

  // stalled result word holds
  `ASSERT_CHK(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(vertex_o) && $stable(parent_o) && $stable(last_o)))

  // no loading while a run still has result words to give
  `ASSERT_CHK(a_no_load_mid_run, (out_valid_o && !last_o) |-> !in_ready_o)

  // valid drops once the final word is taken
  `ASSERT_CHK(a_idle_after_last, (out_valid_o && out_ready_i && last_o) |=> !out_valid_o)

  // a loaded word never produces a result in the next cycle
  `ASSERT_CHK(a_load_no_result, (in_valid_i && in_ready_o) |=> (!out_valid_o || last_o))

endmodule

bind dense_prim_mst_top dpm_checker #(.VERT_BITS($clog2(MAX_VERTICES))) u_dpm_checker (.*);

>>> bench/testbench.sv
// Testbench for dense_prim_mst_top: streams weight matrices, predicts each tree, checks parents.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned MAX_V       = 64;
  localparam int unsigned WEIGHT_BITS = 24;
  localparam int unsigned VID_BITS    = $clog2(MAX_V);
  localparam int unsigned CFG_BITS    = dpm_pkg::CFG_BITS;
  localparam logic [WEIGHT_BITS-1:0] INF_W = '1;
  // Well above the longest quiet spell of an 8-vertex run.
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned RAND_ITEMS  = 175;
  // No idling in phases that start once more than this many random words have gone in.
  localparam int unsigned IDLE_OFF_AT = 135;
  // Settle time after the last parent word before touching the register.
  localparam int unsigned SETTLE      = 12;

  typedef struct packed {
    logic [VID_BITS-1:0] vertex;
    logic [VID_BITS-1:0] parent;
    logic                last;
  } tree_edge_t;

  // Shadow of the block: matrix store, load position, and queue of predicted tree edges.
  class mst_scoreboard;
    logic [WEIGHT_BITS-1:0] weight_mem [MAX_V][MAX_V];
    logic [CFG_BITS-1:0]    count_reg = dpm_pkg::VCOUNT_RESET;
    int unsigned            load_pos  = 0;
    tree_edge_t             pending [$];
    int unsigned            errors    = 0;

    // Out-of-range counts saturate to 2 and MAX_V.
    function int unsigned vertices_for(logic [CFG_BITS-1:0] c);
      if (c < 2) return 2;
      if (c > MAX_V) return MAX_V;
      return c;
    endfunction

    // A register write also restarts the matrix load.
    function void set_count(logic [CFG_BITS-1:0] c);
      count_reg = c;
      load_pos  = 0;
    endfunction

    function void note_weight(logic [WEIGHT_BITS-1:0] w);
      int unsigned n;
      n = vertices_for(count_reg);
      weight_mem[load_pos / n][load_pos % n] = w;
      load_pos++;
      if (load_pos == n * n) begin
        load_pos = 0;
        solve_tree(n);
      end
    endfunction

    // Dense Prim from vertex 0; strict minimum, round counter as fallback pick.
    function void solve_tree(int unsigned n);
      logic [WEIGHT_BITS-1:0] tent_dist [MAX_V];
      bit                     joined    [MAX_V];
      logic [VID_BITS-1:0]    parent_of [MAX_V];
      logic [WEIGHT_BITS-1:0] best;
      logic [WEIGHT_BITS-1:0] w;
      int unsigned            pick;
      tree_edge_t             e;
      for (int unsigned v = 0; v < n; v++) begin
        tent_dist[v] = INF_W;
        joined[v]    = 1'b0;
        parent_of[v] = '0;
      end
      tent_dist[0] = '0;
      joined[0]    = 1'b1;
      for (int unsigned r = 0; r + 1 < n; r++) begin
        best = INF_W;
        pick = r;
        for (int unsigned v = 0; v < n; v++) begin
          if (!joined[v] && tent_dist[v] < best) begin
            best = tent_dist[v];
            pick = v;
          end
        end
        joined[pick] = 1'b1;
        // Zero means no edge; the infinite weight can never win the strict compare.
        for (int unsigned v = 0; v < n; v++) begin
          w = weight_mem[pick][v];
          if (w != '0 && !joined[v] && w < tent_dist[v]) begin
            parent_of[v] = VID_BITS'(pick);
            tent_dist[v] = w;
          end
        end
      end
      for (int unsigned v = 1; v < n; v++) begin
        e.vertex = VID_BITS'(v);
        e.parent = parent_of[v];
        e.last   = (v == n - 1);
        pending  = {pending, e};
      end
    endfunction

    function void check_result(logic [VID_BITS-1:0] vertex, logic [VID_BITS-1:0] parent,
                               logic last);
      tree_edge_t e;
      if (pending.size() == 0) begin
        $error("unexpected parent word: vertex %0d parent %0d last %0d", vertex, parent, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vertex !== e.vertex) begin
        $error("vertex: expected %0d, actual %0d", e.vertex, vertex);
        errors++;
      end
      if (parent !== e.parent) begin
        $error("parent: expected %0d, actual %0d", e.parent, parent);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_BITS-1:0]    cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [WEIGHT_BITS-1:0] weight_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [VID_BITS-1:0]    vertex_o;
  logic [VID_BITS-1:0]    parent_o;
  logic                   last_o;

  mst_scoreboard scb;
  bit            idle_on      = 1'b0;
  int unsigned   hold_left    = 0;
  int unsigned   quiet_cycles = 0;

  dense_prim_mst_top #(
    .MAX_VERTICES(MAX_V),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .weight_i   (weight_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .vertex_o   (vertex_o),
    .parent_o   (parent_o),
    .last_o     (last_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Result side: check accepted words, stall ready in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      scb.check_result(vertex_o, parent_o, last_o);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= (hold_left == 0);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles where no word moves on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("dense_prim_mst_top: mismatch");
        $finish;
      end
    end
  end

  // Matrix entry: no-edge at the given percent, else half small weights (ties common), a tenth infinite.
  function automatic logic [WEIGHT_BITS-1:0] rand_weight(input int unsigned zero_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct) return '0;
    roll = $urandom_range(0, 9);
    if (roll == 0) return INF_W;
    if (roll < 6) return WEIGHT_BITS'($urandom_range(1, 15));
    return WEIGHT_BITS'($urandom);
  endfunction

  // Valid stays up between back-to-back words; it drops only before a gap.
  task automatic send_weight(input logic [WEIGHT_BITS-1:0] w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    weight_i   <= w;
    do @(posedge clk_i); while (!in_ready_o);
    scb.note_weight(w);
  endtask

  task automatic write_count(input logic [CFG_BITS-1:0] c);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scb.set_count(c);
  endtask

  task automatic load_random_matrix(input int unsigned n);
    int unsigned zero_pct;
    zero_pct = $urandom_range(0, 80);
    for (int unsigned k = 0; k < n * n; k++) send_weight(rand_weight(zero_pct));
  endtask

  // Drain all parent words, then let the block settle before the next register write.
  task automatic end_phase();
    in_valid_i <= 1'b0;
    while (scb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_BITS-1:0] cfg;
    int unsigned         n;
    int unsigned         rand_items;
    int unsigned         sel;

    scb = new;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    weight_i    <= '0;
    out_ready_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // Count 0 saturates to 2; no edges at all, every parent stays 0
    write_count(CFG_BITS'(0));
    repeat (4) send_weight('0);
    end_phase();

    // Count 1 saturates to 2; all weights infinite
    write_count(CFG_BITS'(1));
    repeat (4) send_weight(INF_W);
    end_phase();

    // Three vertices: vertex 2 unreachable, infinite edge from 1 never relaxes it
    write_count(CFG_BITS'(3));
    send_weight('0);   send_weight(24'd3); send_weight('0);
    send_weight(24'd3); send_weight('0);   send_weight(INF_W);
    send_weight(24'd1); send_weight(INF_W); send_weight('0);
    end_phase();

    // Register write part way through a load restarts it
    write_count('1);
    send_weight(INF_W);
    send_weight('0);
    in_valid_i <= 1'b0;
    write_count(CFG_BITS'(2));
    send_weight(24'd5); send_weight(24'hFFFFFE); send_weight(24'h800000); send_weight('0);
    end_phase();

    // Random phases over small graphs; low counts saturate to 2
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items > IDLE_OFF_AT) idle_on = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 10) cfg = CFG_BITS'($urandom_range(0, 1));
      else if (sel < 85) cfg = CFG_BITS'($urandom_range(2, 5));
      else cfg = CFG_BITS'($urandom_range(6, 8));
      n = scb.vertices_for(cfg);

      // Occasionally an aborted load under a random count first
      if ($urandom_range(0, 9) == 0) begin
        write_count(CFG_BITS'($urandom_range(0, 127)));
        repeat ($urandom_range(1, 3)) begin
          send_weight(rand_weight(20));
          rand_items++;
        end
        in_valid_i <= 1'b0;
      end
      write_count(cfg);

      repeat ($urandom_range(1, 3)) begin
        if (rand_items < RAND_ITEMS) begin
          load_random_matrix(n);
          rand_items += n * n;
        end
      end
      end_phase();
    end

    repeat (20) @(posedge clk_i);
    if (scb.errors == 0 && scb.pending.size() == 0) begin
      $display("dense_prim_mst_top: match");
    end else begin
      $display("dense_prim_mst_top: mismatch");
    end
    $finish;
  end

endmodule
